FILE: hdl/pdc_pkg.sv
package pdc_pkg;

  localparam int unsigned ErrW   = 16;
  localparam int unsigned GainW  = 16;
  localparam int unsigned SumW   = 32;
  localparam int unsigned LimitW = 15;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned CfgW   = 16;

  // register indexes on the configuration port
  localparam logic [IdxW-1:0] REG_KP_GAIN         = 3'd0;
  localparam logic [IdxW-1:0] REG_KI_GAIN         = 3'd1;
  localparam logic [IdxW-1:0] REG_KD_GAIN         = 3'd2;
  localparam logic [IdxW-1:0] REG_INTEGRAL_LIMIT  = 3'd3;
  localparam logic [IdxW-1:0] REG_POWER_LIMIT     = 3'd4;
  localparam logic [IdxW-1:0] REG_INTEGRAL_ENABLE = 3'd5;

  localparam logic [GainW-1:0]  RST_GAIN            = 16'd0;
  localparam logic [ErrW-1:0]   RST_INTEGRAL_LIMIT  = 16'h7fff;
  localparam logic [LimitW-1:0] RST_POWER_LIMIT     = 15'd200;
  localparam logic              RST_INTEGRAL_ENABLE = 1'b1;

  localparam logic signed [SumW:0] SUM_MAX = 33'sh0_7fff_ffff;
  localparam logic signed [SumW:0] SUM_MIN = 33'sh1_8000_0000;

  typedef struct packed {
    logic signed [GainW-1:0]  kp_gain;
    logic signed [GainW-1:0]  ki_gain;
    logic signed [GainW-1:0]  kd_gain;
    logic signed [ErrW-1:0]   integral_limit;
    logic        [LimitW-1:0] power_limit;
    logic                     integral_enable;
  } cfg_t;

  // operands handed from the state stage to the product stage
  typedef struct packed {
    logic signed [ErrW-1:0] error;
    logic signed [ErrW:0]   delta;
    logic signed [SumW-1:0] integ;
  } stage_t;

endpackage

FILE: hdl/pdc_cfg.sv
module pdc_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pdc_pkg::IdxW-1:0]    cfg_index,
  input  logic [pdc_pkg::CfgW-1:0]    cfg_wdata,
  output pdc_pkg::cfg_t               cfg
);

  pdc_pkg::cfg_t cfg_r;
  pdc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        pdc_pkg::REG_KP_GAIN:         cfg_nxt.kp_gain = cfg_wdata;
        pdc_pkg::REG_KI_GAIN:         cfg_nxt.ki_gain = cfg_wdata;
        pdc_pkg::REG_KD_GAIN:         cfg_nxt.kd_gain = cfg_wdata;
        pdc_pkg::REG_INTEGRAL_LIMIT:  cfg_nxt.integral_limit = cfg_wdata;
        pdc_pkg::REG_POWER_LIMIT:     cfg_nxt.power_limit = cfg_wdata[pdc_pkg::LimitW-1:0];
        pdc_pkg::REG_INTEGRAL_ENABLE: cfg_nxt.integral_enable = cfg_wdata[0];
        default:                      cfg_nxt = cfg_r; // drop writes beyond the map
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_gain         <= pdc_pkg::RST_GAIN;
      cfg_r.ki_gain         <= pdc_pkg::RST_GAIN;
      cfg_r.kd_gain         <= pdc_pkg::RST_GAIN;
      cfg_r.integral_limit  <= pdc_pkg::RST_INTEGRAL_LIMIT;
      cfg_r.power_limit     <= pdc_pkg::RST_POWER_LIMIT;
      cfg_r.integral_enable <= pdc_pkg::RST_INTEGRAL_ENABLE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/pdc_front.sv
module pdc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pdc_pkg::cfg_t             cfg,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [pdc_pkg::ErrW-1:0]  in_tdata,
  input  logic                      back_ready,
  output logic                      s_valid,
  output pdc_pkg::stage_t           s_data
);

  logic                              s_valid_r;
  pdc_pkg::stage_t                   s_data_r;
  pdc_pkg::stage_t                   s_data_nxt;
  logic signed [pdc_pkg::ErrW-1:0]   last_error_r;
  logic signed [pdc_pkg::SumW-1:0]   error_sum_r;
  logic signed [pdc_pkg::SumW-1:0]   error_sum_nxt;
  logic signed [pdc_pkg::ErrW-1:0]   err;
  logic signed [pdc_pkg::SumW:0]     acc;
  logic                              take;

  assign in_tready = !s_valid_r || back_ready;
  assign take      = in_tvalid && in_tready;
  assign err       = $signed(in_tdata);

  always_comb begin
    acc = $signed({error_sum_r[pdc_pkg::SumW-1], error_sum_r}) +
          $signed({{(pdc_pkg::SumW + 1 - pdc_pkg::ErrW){err[pdc_pkg::ErrW-1]}}, err});
    error_sum_nxt = error_sum_r;
    if (cfg.integral_enable) begin
      if (err < cfg.integral_limit) begin
        // saturate at the signed 32-bit bounds
        if (acc > pdc_pkg::SUM_MAX) begin
          error_sum_nxt = pdc_pkg::SUM_MAX[pdc_pkg::SumW-1:0];
        end else if (acc < pdc_pkg::SUM_MIN) begin
          error_sum_nxt = pdc_pkg::SUM_MIN[pdc_pkg::SumW-1:0];
        end else begin
          error_sum_nxt = acc[pdc_pkg::SumW-1:0];
        end
      end else begin
        error_sum_nxt = '0;
      end
    end
    s_data_nxt.error = err;
    s_data_nxt.delta = $signed({err[pdc_pkg::ErrW-1], err}) -
                       $signed({last_error_r[pdc_pkg::ErrW-1], last_error_r});
    // PD mode: the integral term contributes nothing
    s_data_nxt.integ = cfg.integral_enable ? error_sum_nxt : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r    <= 1'b0;
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else begin
      if (in_tready) begin
        s_valid_r <= in_tvalid;
      end
      if (take) begin
        last_error_r <= err;
        error_sum_r  <= error_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_data_r <= s_data_nxt;
    end
  end

  assign s_valid = s_valid_r;
  assign s_data  = s_data_r;

endmodule

FILE: hdl/pdc_back.sv
module pdc_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pdc_pkg::cfg_t             cfg,
  input  logic                      s_valid,
  input  pdc_pkg::stage_t           s_data,
  output logic                      back_ready,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [pdc_pkg::ErrW-1:0]  out_tdata,
  output logic [0:0]                out_tuser
);

  localparam int unsigned PW = 32;
  localparam int unsigned DW = 33;
  localparam int unsigned IW = 48;
  localparam int unsigned TW = 50;
  localparam int unsigned QW = TW - 8;

  logic                            out_tvalid_r;
  logic [pdc_pkg::ErrW-1:0]        drive_r;
  logic [pdc_pkg::ErrW-1:0]        drive_nxt;
  logic                            clamped_r;
  logic                            clamped_nxt;
  logic signed [PW-1:0]            p_term;
  logic signed [DW-1:0]            d_term;
  logic signed [IW-1:0]            i_term;
  logic signed [TW-1:0]            total;
  logic signed [QW-1:0]            q;
  logic signed [QW-1:0]            pos_lim;
  logic signed [QW-1:0]            neg_lim;

  assign back_ready = !out_tvalid_r || out_tready;

  always_comb begin
    p_term  = cfg.kp_gain * s_data.error;
    d_term  = cfg.kd_gain * s_data.delta;
    i_term  = cfg.ki_gain * s_data.integ;
    total   = TW'(p_term) + TW'(d_term) + TW'(i_term);
    q       = QW'(total >>> 8);   // floor division by 256
    pos_lim = $signed({{(QW - pdc_pkg::LimitW){1'b0}}, cfg.power_limit});
    neg_lim = -pos_lim;
    clamped_nxt = 1'b0;
    drive_nxt   = q[pdc_pkg::ErrW-1:0];
    if (q > pos_lim) begin
      drive_nxt   = pos_lim[pdc_pkg::ErrW-1:0];
      clamped_nxt = 1'b1;
    end else if (q < neg_lim) begin
      drive_nxt   = neg_lim[pdc_pkg::ErrW-1:0];
      clamped_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (back_ready) begin
      out_tvalid_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (back_ready && s_valid) begin
      drive_r   <= drive_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = drive_r;
  assign out_tuser[0] = clamped_r;

endmodule

FILE: hdl/pid_drive_controller.sv
// PID drive controller. Each input transaction carries one signed error sample and
// yields one output transaction with the drive value
// (kp*e + ki*I + kd*(e - last)) >>> 8, gains signed Q8.8, clamped to +/- power_limit,
// and a flag that marks when the clamp acted. The integral adds e while e is below
// integral_limit, clears otherwise, and saturates at 32 bits; integral_enable = 0 gives
// PD-only operation with the integral left untouched. The block takes one sample per
// clock unless out_tready holds back the output: the integral and previous-error
// registers update as a sample is taken, and a second register stage forms the three
// products, the sum and the clamp. Write configuration only while the block is idle.
module pid_drive_controller (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,    // [15:0] error_sample
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [15:0]                 out_tdata,   // [15:0] drive
  output logic [0:0]                  out_tuser,   // [0] clamped
  input  logic                        cfg_we,
  input  logic [pdc_pkg::IdxW-1:0]    cfg_index,
  input  logic [pdc_pkg::CfgW-1:0]    cfg_wdata
);

  pdc_pkg::cfg_t   cfg;
  pdc_pkg::stage_t s_data;
  logic            s_valid;
  logic            back_ready;

  pdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  pdc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .back_ready (back_ready),
    .s_valid    (s_valid),
    .s_data     (s_data)
  );

  pdc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s_valid    (s_valid),
    .s_data     (s_data),
    .back_ready (back_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
